[sv/button_debounce_autorepeat_macros.svh]
// ----------------------------------------------------------------------------
// Keypad debounce assertion macros
// Concurrent check wrappers on clk and arst_n; compiled out under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset
`define BDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`else

`define BDA_ASSERT(lbl, prop, msg)

`define BDA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/bda_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad debounce package
// Beat types, register indexes and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

	// Register file
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

	localparam int SETTLE_W = 10;
	localparam int HOLD_W   = 16;
	localparam int PER_W    = 10;
	localparam logic [SETTLE_W-1:0] SETTLE_RST = 10'd150;
	localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd1000;
	localparam logic [PER_W-1:0]    REPEAT_RST = 10'd100;

	// Keypad byte decode
	localparam logic [3:0] KEY_TAG = 4'hB;
	localparam int BTN_W  = 4;
	localparam int TIME_W = 32;

	// Autorepeat bookkeeping
	localparam int REP_W = 16;
	localparam logic [REP_W-1:0] REPEAT_MAX = 16'hFFFF;
	localparam int MAX_BURST   = 16;
	localparam int BURST_LIMIT = (MAX_BURST < 1) ? 1 : ((MAX_BURST > 16) ? 16 : MAX_BURST);
	localparam int CNT_W       = $clog2(BURST_LIMIT + 1);

	// Divider
	localparam int STEP_W = $clog2(TIME_W);

	typedef struct packed {
		logic [7:0]        rx_byte;
		logic [TIME_W-1:0] now_ms;
	} rx_beat_t;

	typedef struct packed {
		logic [BTN_W-1:0] pushed_buttons;
		logic             last;
	} push_beat_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [PER_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [TIME_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] count;
		logic [BTN_W-1:0] buttons;
	} emit_cmd_t;

endpackage

`default_nettype wire

[sv/bda_div.sv]
// ----------------------------------------------------------------------------
// Keypad debounce divider
// Restoring divider, one quotient bit per cycle, for the autorepeat count.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bda_pkg::div_req_t req,
	output bda_pkg::div_rsp_t rsp
);
	import bda_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] quo_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W-1:0]  dvs_q;

	logic [PER_W:0] trial;
	logic [PER_W:0] diff;
	logic           ge;

	assign trial = {rem_q, quo_q[TIME_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(TIME_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_W-2:0], ge};
			rem_q <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[sv/bda_emit.sv]
// ----------------------------------------------------------------------------
// Keypad debounce push emitter
// Counts out a burst of push beats into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  bda_pkg::emit_cmd_t  cmd,
	output logic                busy,
	output logic                push_valid,
	input  logic                push_stall,
	output bda_pkg::push_beat_t push_beat
);
	import bda_pkg::*;

	logic [CNT_W-1:0] remaining_q;
	logic [BTN_W-1:0] btn_q;
	logic             valid_q;
	push_beat_t       beat_q;
	logic             take;
	logic             pending;

	assign take    = !valid_q || !push_stall;
	assign pending = remaining_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			valid_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				remaining_q <= cmd.count;
			end else if (pending && take) begin
				remaining_q <= remaining_q - 1'b1;
			end
			if (take) begin
				valid_q <= pending;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			btn_q <= cmd.buttons;
		end
		if (pending && take) begin
			beat_q.pushed_buttons <= btn_q;
			beat_q.last           <= remaining_q == CNT_W'(1);
		end
	end

	assign busy       = pending;
	assign push_valid = valid_q;
	assign push_beat  = beat_q;

endmodule

`default_nettype wire

[sv/button_debounce_autorepeat.sv]
// ----------------------------------------------------------------------------
// Keypad debounce with autorepeat
// Turns keypad status bytes into pushed-button beats: release, settle, repeat.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Beat           Direction
//  -------   ---------------------   ------------   ---------
//  rx        rx_valid / rx_stall     rx_beat_t      in
//  push      push_valid / push_stall push_beat_t    out
//  cfg       cfg_we                  index + data   in
//
// A byte that is not a status byte, or a status byte with no push, goes from
// capture through S_DIFF and S_EVAL back to idle. A status byte with a single
// push also passes S_EMIT. An autorepeat byte, with up to 16 beats, also waits
// in S_DIV on the bit-serial divider (32 quotient bits and a done strobe) that
// turns held time into a count, then passes S_TGT and S_EMIT. rx_stall stays high
// from acceptance until the cycle after the last beat of the burst enters the
// output register; push_stall holds that register and the rest of the burst.
// Reset clears the control and debounce state and loads the register defaults.
//
`default_nettype none

`include "button_debounce_autorepeat_macros.svh"

module button_debounce_autorepeat (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bda_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bda_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                rx_valid,
	output logic                                rx_stall,
	input  bda_pkg::rx_beat_t                   rx_beat,
	output logic                                push_valid,
	input  logic                                push_stall,
	output bda_pkg::push_beat_t                 push_beat
);
	import bda_pkg::*;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIFF = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_TGT  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	// Decision codes for a status byte
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_UNLOCK  = 3'd1;
	localparam logic [2:0] ACT_RELEASE = 3'd2;
	localparam logic [2:0] ACT_SETTLE  = 3'd3;
	localparam logic [2:0] ACT_REPEAT  = 3'd4;
	localparam logic [2:0] ACT_LOCK    = 3'd5;

	logic [2:0] state_q;

	// Registers
	logic [SETTLE_W-1:0] settle_q;
	logic [HOLD_W-1:0]   hold_q;
	logic [PER_W-1:0]    repeat_q;

	// Debounce state
	logic [BTN_W-1:0]  prev_q;
	logic [TIME_W-1:0] chg_q;
	logic [REP_W-1:0]  rep_q;
	logic              await_q;

	// Captured beat and elapsed time
	logic [7:0]        rx_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] stable_q;

	logic [BTN_W-1:0]  status;
	logic [BTN_W-1:0]  overlap;
	logic              key_hit;
	logic              changed;
	logic              settle_hit;
	logic              hold_hit;
	logic [2:0]        act;

	logic [REP_W-1:0]  target;
	logic [REP_W-1:0]  gap;
	logic [CNT_W-1:0]  rpt_cnt;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	emit_cmd_t emit_cmd;
	logic      emit_busy;

	assign rx_stall = state_q != S_IDLE;

	// Decode: the status nibble arrives inverted
	assign status     = ~rx_q[BTN_W-1:0];
	assign key_hit    = rx_q[7:4] == KEY_TAG;
	assign changed    = status != prev_q;
	assign overlap    = status & prev_q;
	assign settle_hit = stable_q >= {{(TIME_W-SETTLE_W){1'b0}}, settle_q};
	assign hold_hit   = stable_q >= {{(TIME_W-HOLD_W){1'b0}}, hold_q};

	// Pick one action per status byte, in priority order
	always_comb begin
		act = ACT_NONE;
		if (await_q) begin
			if (status == '0) begin
				act = ACT_UNLOCK;
			end
		end else if (prev_q != '0) begin
			if (overlap == '0) begin
				if (rep_q == '0) begin
					act = ACT_RELEASE;
				end
			end else if (settle_hit && rep_q == '0) begin
				act = ACT_SETTLE;
			end else if (hold_hit) begin
				act = ACT_REPEAT;
			end else if (overlap != prev_q) begin
				act = ACT_LOCK;
			end
		end
	end

	// Autorepeat target from the quotient, saturated; burst clipped to the limit
	always_comb begin
		if (div_rsp.quotient >= {{(TIME_W-REP_W){1'b0}}, REPEAT_MAX - 16'd1}) begin
			target = REPEAT_MAX;
		end else begin
			target = div_rsp.quotient[REP_W-1:0] + 16'd1;
		end
		gap = target - rep_q;
		if (target <= rep_q) begin
			rpt_cnt = '0;
		end else if (gap > REP_W'(BURST_LIMIT)) begin
			rpt_cnt = CNT_W'(BURST_LIMIT);
		end else begin
			rpt_cnt = gap[CNT_W-1:0];
		end
	end

	// Divider request: held time past the hold delay over the repeat period
	assign div_req.start    = (state_q == S_EVAL) && key_hit && (act == ACT_REPEAT);
	assign div_req.dividend = stable_q - {{(TIME_W-HOLD_W){1'b0}}, hold_q};
	assign div_req.divisor  = (repeat_q == '0) ? PER_W'(1) : repeat_q;

	// Emitter command: single pushes from EVAL, autorepeat bursts from TGT
	always_comb begin
		emit_cmd.load    = 1'b0;
		emit_cmd.count   = CNT_W'(1);
		emit_cmd.buttons = status;
		if (state_q == S_EVAL && key_hit) begin
			if (act == ACT_RELEASE) begin
				emit_cmd.load    = 1'b1;
				emit_cmd.buttons = prev_q;
			end else if (act == ACT_SETTLE) begin
				emit_cmd.load = 1'b1;
			end
		end else if (state_q == S_TGT) begin
			emit_cmd.load    = 1'b1;
			emit_cmd.count   = rpt_cnt;
			emit_cmd.buttons = prev_q;
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RST;
			hold_q   <= HOLD_RST;
			repeat_q <= REPEAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE: settle_q <= cfg_data[SETTLE_W-1:0];
				REG_HOLD:   hold_q   <= cfg_data[HOLD_W-1:0];
				REG_REPEAT: repeat_q <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the beat, then the elapsed time since the last change
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && rx_valid) begin
			rx_q  <= rx_beat.rx_byte;
			now_q <= rx_beat.now_ms;
		end
		if (state_q == S_DIFF) begin
			stable_q <= changed ? '0 : now_q - chg_q;
		end
	end

	// Sequencer and debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_q  <= '0;
			chg_q   <= '0;
			rep_q   <= '0;
			await_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rx_valid) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!key_hit) begin
						// drop anything that is not a status byte
						state_q <= S_IDLE;
					end else begin
						if (changed) begin
							chg_q <= now_q;
						end
						case (act)
							ACT_UNLOCK: await_q <= 1'b0;
							ACT_SETTLE: rep_q   <= REP_W'(1);
							ACT_LOCK:   await_q <= 1'b1;
							default: ;
						endcase
						if (status == '0) begin
							rep_q <= '0;
						end
						prev_q <= status;
						if (act inside {ACT_RELEASE, ACT_SETTLE}) begin
							state_q <= S_EMIT;
						end else if (act == ACT_REPEAT) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_TGT;
					end
				end
				S_TGT: begin
					// advance the repeat count by the burst handed out now
					rep_q   <= rep_q + REP_W'(rpt_cnt);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!emit_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	bda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bda_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (emit_cmd),
		.busy       (emit_busy),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_beat  (push_beat)
	);

	// A held partial release always has some button down
	`BDA_ASSERT(a_lock_has_press, await_q |-> prev_q != '0, "release lock with no button held")
	// All buttons up means the repeat count is cleared
	`BDA_ASSERT(a_rep_clear, prev_q == '0 |-> rep_q == '0, "repeat count left over after release")
	// A new burst never lands on one still being counted out
	`BDA_ASSERT(a_load_free, emit_cmd.load |-> !emit_busy, "burst loaded while emitter busy")
	// A divider start is followed by a busy divider
	`BDA_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy, "divider did not start")

endmodule

`default_nettype wire
